// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion macros for the RTL file that carries checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge, skipped while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property at every rising clock edge, also while reset is high.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: design/lsme_pkg.sv
// ----------------------------------------------------------------------------
// lsme_pkg
// Types, codes and sizes shared by the LED strip mirror engine.
// ----------------------------------------------------------------------------
package lsme_pkg;

   localparam int STRIP_LEN = 160;
   localparam int PIX_AW    = $clog2(STRIP_LEN);
   localparam int POS_W     = PIX_AW + 1;
   localparam int CENTER_W  = 10;
   localparam int CHAN_W    = 8;

   localparam logic [PIX_AW-1:0]   STRIP_LEN_A = PIX_AW'(STRIP_LEN);
   localparam logic [POS_W-1:0]    STRIP_LEN_P = POS_W'(STRIP_LEN);
   localparam logic [CENTER_W-1:0] STRIP_LEN_C = CENTER_W'(STRIP_LEN);
   localparam logic [PIX_AW-1:0]   HALF_LEN_A  = PIX_AW'(STRIP_LEN / 2);

   // Request kinds
   localparam logic [1:0] KIND_WRITE = 2'd0;
   localparam logic [1:0] KIND_APPLY = 2'd1;
   localparam logic [1:0] KIND_READ  = 2'd2;

   // Result kinds
   localparam logic RES_PIXEL = 1'b0;
   localparam logic RES_APPLY = 1'b1;

   // Mirror modes
   localparam logic [1:0] MODE_L2R   = 2'd0;
   localparam logic [1:0] MODE_R2L   = 2'd1;
   localparam logic [1:0] MODE_AVG   = 2'd2;
   localparam logic [1:0] MODE_KALEI = 2'd3;

   // Register indexes
   localparam logic [1:0] CSR_ENABLE = 2'd0;
   localparam logic [1:0] CSR_MODE   = 2'd1;
   localparam logic [1:0] CSR_CENTER = 2'd2;

   typedef struct packed {
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] red;
   } pixel_type;

   typedef struct packed {
      logic                enable;
      logic [1:0]          mode;
      logic [CENTER_W-1:0] center;
   } cfg_type;

   typedef struct packed {
      logic              wr_en;
      logic [PIX_AW-1:0] wr_addr;
      pixel_type         wr_data;
      logic              rd_en;
      logic [PIX_AW-1:0] rd_addr;
   } ram_ctl_type;

   typedef struct packed {
      logic      load;
      logic      kind;
      pixel_type data;
   } res_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_APPLY_DONE,
      ST_WALK_A,
      ST_WALK_B,
      ST_WALK_AVG,
      ST_WALK_W
   } state_type;

endpackage

// File: design/lsme_pixel_ram.sv
// ----------------------------------------------------------------------------
// lsme_pixel_ram
// Pixel store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lsme_pixel_ram
   import lsme_pkg::*;
(
   input  logic        clock,
   input  ram_ctl_type ctl,
   output pixel_type   rd_data
);

   pixel_type mem [STRIP_LEN];
   pixel_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[ctl.wr_addr] <= ctl.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff <= mem[ctl.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/lsme_walk_seq.sv
// ----------------------------------------------------------------------------
// lsme_walk_seq
// Command sequencer: pixel writes and reads, and the mirror walk that steps
// one pair of positions at a time through the shared address unit.
// ----------------------------------------------------------------------------
module lsme_walk_seq
   import lsme_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [1:0]        kind,
   input  logic [PIX_AW-1:0] pixel_index,
   input  pixel_type         pixel_in,
   input  cfg_type           cfg,
   input  logic              slot_free,
   input  pixel_type         ram_rd_data,
   output ram_ctl_type       ram_ctl,
   output res_type           res,
   output logic              idle
);

   state_type         state_ff, state_in;
   logic [PIX_AW-1:0] k_ff, k_in;
   logic [PIX_AW-1:0] lim_ff, lim_in;
   logic [POS_W-1:0]  abase_ff, abase_in;
   logic [POS_W-1:0]  bbase_ff, bbase_in;
   logic              phase_a_ff, phase_a_in;
   logic              oor_ff, oor_in;
   pixel_type         hold_ff, hold_in;

   logic [PIX_AW-1:0] ctr;
   logic [PIX_AW-1:0] quarter;
   logic [POS_W-1:0]  two_c_m1;
   logic [POS_W-1:0]  two_q_m1;
   logic [POS_W-1:0]  pos_a;
   logic [POS_W-1:0]  pos_b;
   logic              pair_ok;
   logic              avg_mode;
   logic [CHAN_W:0]   sum_r, sum_g, sum_b;
   pixel_type         avg_px;

   // Clamp the center, derive the walk bounds
   always_comb begin
      ctr      = (cfg.center >= STRIP_LEN_C) ? HALF_LEN_A : cfg.center[PIX_AW-1:0];
      quarter  = ctr >> 1;
      two_c_m1 = {1'b0, ctr} + {1'b0, ctr} - POS_W'(1);
      two_q_m1 = {1'b0, quarter} + {1'b0, quarter} - POS_W'(1);
      avg_mode = (cfg.mode == MODE_AVG);
   end

   // Shared address unit
   always_comb begin
      pos_a   = abase_ff + {1'b0, k_ff};
      pos_b   = bbase_ff - {1'b0, k_ff};
      pair_ok = (pos_a < STRIP_LEN_P) && (pos_b < STRIP_LEN_P);
   end

   always_comb begin
      sum_r  = {1'b0, hold_ff.red}   + {1'b0, ram_rd_data.red};
      sum_g  = {1'b0, hold_ff.green} + {1'b0, ram_rd_data.green};
      sum_b  = {1'b0, hold_ff.blue}  + {1'b0, ram_rd_data.blue};
      avg_px = '{blue: sum_b[CHAN_W:1], green: sum_g[CHAN_W:1], red: sum_r[CHAN_W:1]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         k_ff       <= '0;
         phase_a_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         k_ff       <= k_in;
         phase_a_ff <= phase_a_in;
      end
   end

   always_ff @(posedge clock) begin
      lim_ff   <= lim_in;
      abase_ff <= abase_in;
      bbase_ff <= bbase_in;
      oor_ff   <= oor_in;
      hold_ff  <= hold_in;
   end

   always_comb begin
      state_in   = state_ff;
      k_in       = k_ff;
      lim_in     = lim_ff;
      abase_in   = abase_ff;
      bbase_in   = bbase_ff;
      phase_a_in = phase_a_ff;
      oor_in     = oor_ff;
      hold_in    = hold_ff;
      ram_ctl    = '0;
      res        = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (kind)
                  KIND_WRITE: begin
                     ram_ctl.wr_en   = (pixel_index < STRIP_LEN_A);
                     ram_ctl.wr_addr = pixel_index;
                     ram_ctl.wr_data = pixel_in;
                  end
                  KIND_READ: begin
                     oor_in          = (pixel_index >= STRIP_LEN_A);
                     ram_ctl.rd_en   = (pixel_index < STRIP_LEN_A);
                     ram_ctl.rd_addr = pixel_index;
                     state_in        = ST_READ;
                  end
                  KIND_APPLY: begin
                     if (cfg.enable) begin
                        k_in     = '0;
                        state_in = ST_WALK_A;
                        unique case (cfg.mode)
                           MODE_L2R, MODE_AVG: begin
                              lim_in     = ctr;
                              abase_in   = '0;
                              bbase_in   = two_c_m1;
                              phase_a_in = 1'b0;
                           end
                           MODE_R2L: begin
                              lim_in     = ctr;
                              abase_in   = {1'b0, ctr};
                              bbase_in   = {1'b0, ctr} - POS_W'(1);
                              phase_a_in = 1'b0;
                           end
                           MODE_KALEI: begin
                              lim_in     = quarter;
                              abase_in   = '0;
                              bbase_in   = two_q_m1;
                              phase_a_in = 1'b1;
                           end
                        endcase
                     end else begin
                        state_in = ST_APPLY_DONE;
                     end
                  end
                  default: begin
                     // unknown kind: drop the item
                  end
               endcase
            end
         end

         ST_READ: begin
            if (slot_free) begin
               res.load = 1'b1;
               res.kind = RES_PIXEL;
               res.data = oor_ff ? '0 : ram_rd_data;
               state_in = ST_IDLE;
            end
         end

         ST_APPLY_DONE: begin
            if (slot_free) begin
               res.load = 1'b1;
               res.kind = RES_APPLY;
               state_in = ST_IDLE;
            end
         end

         ST_WALK_A: begin
            if (k_ff == lim_ff) begin
               k_in = '0;
               if (phase_a_ff) begin
                  // kaleidoscope: second pass mirrors the left half
                  phase_a_in = 1'b0;
                  lim_in     = ctr;
                  abase_in   = '0;
                  bbase_in   = two_c_m1;
               end else begin
                  state_in = ST_APPLY_DONE;
               end
            end else if (!pair_ok) begin
               k_in = k_ff + PIX_AW'(1);
            end else begin
               ram_ctl.rd_en   = 1'b1;
               ram_ctl.rd_addr = pos_a[PIX_AW-1:0];
               state_in        = avg_mode ? ST_WALK_B : ST_WALK_W;
            end
         end

         ST_WALK_B: begin
            ram_ctl.rd_en   = 1'b1;
            ram_ctl.rd_addr = pos_b[PIX_AW-1:0];
            hold_in         = ram_rd_data;
            state_in        = ST_WALK_AVG;
         end

         ST_WALK_AVG: begin
            ram_ctl.wr_en   = 1'b1;
            ram_ctl.wr_addr = pos_a[PIX_AW-1:0];
            ram_ctl.wr_data = avg_px;
            hold_in         = avg_px;
            state_in        = ST_WALK_W;
         end

         ST_WALK_W: begin
            ram_ctl.wr_en   = 1'b1;
            ram_ctl.wr_addr = pos_b[PIX_AW-1:0];
            ram_ctl.wr_data = avg_mode ? hold_ff : ram_rd_data;
            k_in            = k_ff + PIX_AW'(1);
            state_in        = ST_WALK_A;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign idle = (state_ff == ST_IDLE);

endmodule

// File: design/led_strip_mirror_engine_unit.sv
// Pixel write: stored as the item is accepted. Pixel read: the registered store data goes
//   to the output register. Apply: a pair outside the strip is skipped; any other pair is
//   copied (read A, write B) or averaged (read A, read B, write A, write B); each pass ends,
//   then the result is loaded. Throughput: writes 1 per cycle while the sequencer is idle;
//   the pixel store's single read port and the walk sequencer hold one item at a time for
//   reads and applies. Reset: registers return to enable 1, mode 0, center 80; store is kept.
// ----------------------------------------------------------------------------
// led_strip_mirror_engine_unit
// Holds a strip of RGB pixels and mirrors it in place on an apply command.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module led_strip_mirror_engine_unit
   import lsme_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   // Request item channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // pixel_index[7:0], red_in[15:8],
                                    // green_in[23:16], blue_in[31:24]
   input  logic [1:0]  req_tuser,   // kind[1:0]

   // Result item channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // red_out[7:0], green_out[15:8], blue_out[23:16]
   output logic        rsp_tuser,   // result_kind[0]

   // Register write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [9:0]  csr_data
);

   cfg_type     cfg_ff, cfg_in;
   logic        rsp_valid_ff, rsp_valid_in;
   res_type     rsp_ff, rsp_in;

   logic        req_fire;
   logic        slot_free;
   logic        seq_idle;
   ram_ctl_type ram_ctl;
   pixel_type   ram_rd_data;
   res_type     res;
   pixel_type   pixel_in;

   // Registers are always writable; the host must write them only while idle, the block does not enforce it
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_ENABLE: cfg_in.enable = csr_data[0];
            CSR_MODE:   cfg_in.mode   = csr_data[1:0];
            CSR_CENTER: cfg_in.center = csr_data[CENTER_W-1:0];
            default: begin
               // unknown index: drop the write
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{enable: 1'b1, mode: MODE_L2R, center: CENTER_W'(80)};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Accept a new item whenever the sequencer is idle, even with a result
   // still waiting; the output register parts the two sides.
   assign req_tready = seq_idle;
   assign req_fire   = req_tvalid && req_tready;
   assign pixel_in   = '{blue: req_tdata[31:24], green: req_tdata[23:16],
                         red: req_tdata[15:8]};

   // Let the sequencer load a result when the slot is empty or being drained
   assign slot_free = !rsp_valid_ff || rsp_tready;

   lsme_walk_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .start       (req_fire),
      .kind        (req_tuser),
      .pixel_index (req_tdata[PIX_AW-1:0]),
      .pixel_in    (pixel_in),
      .cfg         (cfg_ff),
      .slot_free   (slot_free),
      .ram_rd_data (ram_rd_data),
      .ram_ctl     (ram_ctl),
      .res         (res),
      .idle        (seq_idle)
   );

   lsme_pixel_ram u_ram (
      .clock   (clock),
      .ctl     (ram_ctl),
      .rd_data (ram_rd_data)
   );

   // Output register: load a new result, otherwise drop the taken one
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res.load) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tdata  = {rsp_ff.data.blue, rsp_ff.data.green, rsp_ff.data.red};

   // Checks
   `ASSERT_CLK(a_wr_in_strip, clock, reset, ram_ctl.wr_en |-> (ram_ctl.wr_addr < STRIP_LEN_A), "pixel store write outside the strip")
   `ASSERT_CLK(a_rd_in_strip, clock, reset, ram_ctl.rd_en |-> (ram_ctl.rd_addr < STRIP_LEN_A), "pixel store read outside the strip")
   `ASSERT_CLK(a_no_overwrite, clock, reset, res.load |-> slot_free, "result loaded over a waiting result")
   `ASSERT_CLK(a_done_zero, clock, reset, (res.load && res.kind == RES_APPLY) |-> (res.data == '0), "apply result carries pixel data")

endmodule

// File: test/led_strip_mirror_engine_unit_test.sv
// ----------------------------------------------------------------------------
// led_strip_mirror_engine_unit_test
// Self-checking bench for the LED strip mirror engine. It fills the strip,
// then runs directed checks on the index bounds, the four mirror modes, the
// disable bit and the center limits. After that come random phases of pixel
// writes, applies and reads, under changing register settings and with
// random gaps on both stream sides. Every result item is checked against a
// local model of the pixel store.
// ----------------------------------------------------------------------------
module led_strip_mirror_engine_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import lsme_pkg::*;

   // Kind and register index codes that the package leaves unnamed
   localparam logic [1:0] KIND_NONE  = 2'd3;
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   // Cycles with no accepted item before the run is declared hung; it must outlast
   // an apply walk plus any stall bursts.
   localparam int STALL_LIMIT = 4000;
   // Idle cycles after the last result, covering a trailing pixel write
   localparam int SETTLE_CYCLES = 4;

   typedef struct {
      logic      kind;
      pixel_type px;
   } result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // pixel_index[7:0], red_in[15:8],
                                  // green_in[23:16], blue_in[31:24]
   logic [1:0]  req_tuser = '0;   // kind[1:0]

   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;        // red_out[7:0], green_out[15:8], blue_out[23:16]
   logic        rsp_tuser;        // result_kind[0]

   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [9:0]  csr_data = '0;

   // Local model of the block: pixel store and register copies
   pixel_type   strip_px [STRIP_LEN];
   logic        cfg_enable = 1'b1;
   logic [1:0]  cfg_mode   = MODE_L2R;
   logic [9:0]  cfg_center = 10'd80;

   // Results still owed by the block, oldest first
   result_type  pending_results [$];
   int          error_count = 0;

   // Percent chance of a sender gap per item, or of a new receiver stall burst
   int          send_gap_pct  = 0;
   int          rsp_stall_pct = 0;

   led_strip_mirror_engine_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Model of an apply: clamp the center, then walk the selected mode in the
   // same order as the hardware so that overlapping passes come out the same.
   // ------------------------------------------------------------------------
   task automatic mirror_strip();
      int unsigned c;
      int unsigned q;
      int unsigned p;
      int unsigned i;
      pixel_type   a;
      pixel_type   b;
      pixel_type   m;
      c = cfg_center;
      // Center at or past the strip end falls back to half length
      if (c >= STRIP_LEN) c = STRIP_LEN / 2;
      case (cfg_mode)
         MODE_L2R: begin
            for (i = 0; i < c; i++) begin
               p = 2 * c - 1 - i;
               if (p < STRIP_LEN) strip_px[p] = strip_px[i];
            end
         end
         MODE_R2L: begin
            // Right half reversed onto the left; only offsets below c land
            for (i = c; i < STRIP_LEN; i++) begin
               if (i - c < c) strip_px[c - 1 - (i - c)] = strip_px[i];
            end
         end
         MODE_AVG: begin
            for (i = 0; i < c; i++) begin
               p = 2 * c - 1 - i;
               // Pairs whose right side leaves the strip stay as they are
               if (p < STRIP_LEN) begin
                  a = strip_px[i];
                  b = strip_px[p];
                  m.red   = 8'((int'(a.red) + int'(b.red)) >> 1);
                  m.green = 8'((int'(a.green) + int'(b.green)) >> 1);
                  m.blue  = 8'((int'(a.blue) + int'(b.blue)) >> 1);
                  strip_px[i] = m;
                  strip_px[p] = m;
               end
            end
         end
         MODE_KALEI: begin
            // First quarter into the second quarter, then left into right
            q = c / 2;
            for (i = 0; i < q; i++) begin
               p = 2 * q - 1 - i;
               if (p < c) strip_px[p] = strip_px[i];
            end
            for (i = 0; i < c; i++) begin
               p = 2 * c - 1 - i;
               if (p < STRIP_LEN) strip_px[p] = strip_px[i];
            end
         end
      endcase
   endtask

   // Update the model for one accepted item and queue the result it owes
   task automatic predict_item(logic [1:0] kind, logic [7:0] idx, pixel_type px);
      result_type r;
      r.kind = RES_PIXEL;
      r.px   = '0;
      case (kind)
         KIND_WRITE: begin
            // Writes past the strip end are dropped
            if (idx < STRIP_LEN) strip_px[idx] = px;
         end
         KIND_APPLY: begin
            if (cfg_enable) mirror_strip();
            r.kind = RES_APPLY;
            pending_results.push_back(r);
         end
         KIND_READ: begin
            // Reads past the strip end answer all zero
            if (idx < STRIP_LEN) r.px = strip_px[idx];
            pending_results.push_back(r);
         end
         default: ;   // unknown kind: no effect, no result
      endcase
   endtask

   // ------------------------------------------------------------------------
   // Send one request item. Hold tvalid across back-to-back items; drop it
   // only for a random gap, and raise it again at a later falling edge.
   // ------------------------------------------------------------------------
   task automatic push_item(logic [1:0] kind, logic [7:0] idx, pixel_type px);
      @(negedge clock);
      if ($urandom_range(0, 99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {px.blue, px.green, px.red, idx};
      do @(posedge clock); while (!req_tready);
      predict_item(kind, idx, px);
   endtask

   task automatic write_pixel(logic [7:0] idx, pixel_type px);
      push_item(KIND_WRITE, idx, px);
   endtask

   task automatic read_pixel(logic [7:0] idx);
      push_item(KIND_READ, idx, pixel_type'($urandom));
   endtask

   task automatic apply_mirror();
      push_item(KIND_APPLY, 8'($urandom), pixel_type'($urandom));
   endtask

   // Drop tvalid, wait for every owed result, then let a trailing write finish
   task automatic settle_block();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write one register; call only while the block is settled
   task automatic write_reg(logic [1:0] index, logic [9:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (index)
         CSR_ENABLE: cfg_enable = data[0];
         CSR_MODE:   cfg_mode   = data[1:0];
         CSR_CENTER: cfg_center = data;
         default:    ;   // unused index is ignored
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // Receiver side: stall rsp_tready in random bursts.
   // ------------------------------------------------------------------------
   initial begin : rsp_stall
      int hold;
      hold = 0;
      forever begin
         @(negedge clock);
         if (hold == 0 && $urandom_range(0, 99) < rsp_stall_pct)
            hold = $urandom_range(1, 16);
         if (hold > 0) begin
            rsp_tready <= 1'b0;
            hold--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endfunction

   // Compare each accepted result with the oldest owed one
   always @(posedge clock) begin : result_check
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("result_kind: expected no result, got %0d", rsp_tuser);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("result_kind", int'(want.kind), int'(rsp_tuser));
            check_field("red_out", int'(want.px.red), int'(rsp_tdata[7:0]));
            check_field("green_out", int'(want.px.green), int'(rsp_tdata[15:8]));
            check_field("blue_out", int'(want.px.blue), int'(rsp_tdata[23:16]));
         end
      end
   end

   // Count cycles in which no channel moves an item; end a hung run
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Write every pixel once, so no later read or apply touches an unwritten one.
   // Pin the ends to all-zero and all-ones channels.
   task automatic test_fill_strip();
      int i;
      for (i = 0; i < STRIP_LEN; i++) begin
         if (i == 0)
            write_pixel(8'(i), '0);
         else if (i == STRIP_LEN - 1)
            write_pixel(8'(i), '1);
         else
            write_pixel(8'(i), pixel_type'($urandom));
      end
   endtask

   // Index bounds: strip ends, indexes past the strip, and an unknown kind
   task automatic test_index_bounds();
      read_pixel(8'd0);
      read_pixel(8'(STRIP_LEN - 1));
      write_pixel(8'(STRIP_LEN), pixel_type'(24'hA5A5A5));
      write_pixel(8'd255, '1);
      read_pixel(8'(STRIP_LEN));
      read_pixel(8'd255);
      push_item(KIND_NONE, 8'd3, '1);
      read_pixel(8'd3);
   endtask

   // Each mirror mode at the reset center, with reads around the split
   task automatic test_each_mode();
      logic [1:0] modes [4] = '{MODE_L2R, MODE_R2L, MODE_AVG, MODE_KALEI};
      int m;
      for (m = 0; m < 4; m++) begin
         settle_block();
         write_reg(CSR_MODE, 10'(modes[m]));
         write_pixel(8'(m * 37), pixel_type'($urandom));
         apply_mirror();
         read_pixel(8'd79);
         read_pixel(8'(STRIP_LEN - 1 - m * 37));
      end
   endtask

   // Apply with the block disabled must leave the pixels alone
   task automatic test_disabled_apply();
      settle_block();
      write_reg(CSR_ENABLE, 10'd0);
      write_reg(CSR_MODE, 10'(MODE_L2R));
      apply_mirror();
      read_pixel(8'd100);
      settle_block();
      write_reg(CSR_ENABLE, 10'd1);
   endtask

   // Center limits, including values past the strip and the unused index
   task automatic test_center_limits();
      logic [9:0] centers [6] = '{10'd0, 10'd1, 10'(STRIP_LEN - 1), 10'(STRIP_LEN),
                                  10'd1023, 10'd2};
      int k;
      for (k = 0; k < 6; k++) begin
         settle_block();
         write_reg(CSR_CENTER, centers[k]);
         write_reg(CSR_MODE, 10'(k % 4));
         write_reg(CSR_UNUSED, 10'($urandom));
         apply_mirror();
         read_pixel(8'd0);
      end
   endtask

   // One random register write, biased toward the extremes
   task automatic random_reg_write();
      logic [9:0] c;
      case ($urandom_range(0, 3))
         0: write_reg(CSR_ENABLE, ($urandom_range(0, 4) == 0) ? 10'd0 : 10'd1);
         1: write_reg(CSR_MODE, 10'($urandom_range(0, 3)));
         2: begin
            case ($urandom_range(0, 5))
               0: c = 10'd0;
               1: c = 10'(STRIP_LEN - 1);
               2: c = 10'd1023;
               3: c = 10'($urandom_range(STRIP_LEN, 1023));
               default: c = 10'($urandom_range(1, STRIP_LEN - 1));
            endcase
            write_reg(CSR_CENTER, c);
         end
         default: write_reg(CSR_UNUSED, 10'($urandom));
      endcase
   endtask

   // Mostly writes, reads and applies inside the strip; the rest is noise
   task automatic run_traffic(int n_items);
      int k;
      int sel;
      for (k = 0; k < n_items; k++) begin
         sel = $urandom_range(0, 99);
         if (sel < 50)
            write_pixel(8'($urandom_range(0, STRIP_LEN - 1)), pixel_type'($urandom));
         else if (sel < 85)
            read_pixel(8'($urandom_range(0, STRIP_LEN - 1)));
         else if (sel < 93)
            apply_mirror();
         else if (sel < 96)
            write_pixel(8'($urandom_range(STRIP_LEN, 255)), pixel_type'($urandom));
         else if (sel < 98)
            read_pixel(8'($urandom_range(STRIP_LEN, 255)));
         else
            push_item(KIND_NONE, 8'($urandom), pixel_type'($urandom));
      end
   endtask

   // Random phases; the sender drains the block before every register change
   task automatic test_random_phases();
      int ph;
      int n;
      for (ph = 0; ph < 12; ph++) begin
         settle_block();
         n = $urandom_range(1, 3);
         repeat (n) random_reg_write();
         // Leave some phases with no gaps at all
         send_gap_pct  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 30);
         rsp_stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 30);
         run_traffic(100);
      end
   endtask

   // Closing stretch at full rate on both sides
   task automatic test_full_rate();
      settle_block();
      send_gap_pct  = 0;
      rsp_stall_pct = 0;
      random_reg_write();
      run_traffic(150);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_fill_strip();
      send_gap_pct  = 20;
      rsp_stall_pct = 20;
      test_index_bounds();
      test_each_mode();
      test_disabled_apply();
      test_center_limits();
      test_random_phases();
      test_full_rate();

      // Drain; the watchdog bounds this wait
      settle_block();
      repeat (8) @(posedge clock);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// File: files.f
+incdir+design
design/lsme_pkg.sv
design/lsme_pixel_ram.sv
design/lsme_walk_seq.sv
design/led_strip_mirror_engine_unit.sv
test/led_strip_mirror_engine_unit_test.sv
